// ===== sv/bbt_pkg.sv =====
// Shared types and constants for the box bounds transform pipeline.
package bbt_pkg;

  localparam int DATA_W          = 32;
  localparam int NUM_AXES        = 3;
  localparam int NUM_COEF        = 4;
  localparam int ROW_W           = 2;
  localparam int PROD_W          = 2 * DATA_W;
  localparam int SUM_W           = PROD_W + 2;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef logic signed [DATA_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [ROW_W-1:0]  row_t;

endpackage

// ===== sv/box_bounds_transform.sv =====
// Top level of the box bounds transform: four-stage pipeline.
//
// One input channel carries two kinds of beat. A load beat (opcode 0) writes
// one matrix row (coef_0..coef_3) to row x, y or z; row_index 3 is ignored.
// A load gives no result and takes effect for the very next transform beat.
// A transform beat (opcode 1) carries a box and gives one result beat: the
// per-axis minimum and maximum of the eight corners mapped through the top
// three matrix rows, truncated to Q16.16 and clamped, with saturated_o set
// when any corner coordinate was clamped.
// Throughput is one beat per cycle while out_stall_i is low. A result goes
// through the product, min/max, sum and saturate stages, each one register,
// and leaves the output register. The product stage holds 18 parallel 32x32
// multipliers, so any mix of loads and boxes flows at one beat per cycle.
// Reset puts the identity matrix in the row registers and empties all stages.
// When out_stall_i is high the output holds; earlier stages keep filling
// empty slots, and in_stall_o rises only when every stage holds a box.
module box_bounds_transform #(
  parameter int FracBits   = bbt_pkg::FRAC_BITS_DEF,
  parameter int CoordWidth = bbt_pkg::COORD_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            opcode_i,
  input  bbt_pkg::row_t   row_index_i,
  input  bbt_pkg::coord_t coef_0_i,
  input  bbt_pkg::coord_t coef_1_i,
  input  bbt_pkg::coord_t coef_2_i,
  input  bbt_pkg::coord_t coef_3_i,
  input  bbt_pkg::coord_t box_min_x_i,
  input  bbt_pkg::coord_t box_min_y_i,
  input  bbt_pkg::coord_t box_min_z_i,
  input  bbt_pkg::coord_t box_max_x_i,
  input  bbt_pkg::coord_t box_max_y_i,
  input  bbt_pkg::coord_t box_max_z_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bbt_pkg::coord_t new_min_x_o,
  output bbt_pkg::coord_t new_min_y_o,
  output bbt_pkg::coord_t new_min_z_o,
  output bbt_pkg::coord_t new_max_x_o,
  output bbt_pkg::coord_t new_max_y_o,
  output bbt_pkg::coord_t new_max_z_o,
  output logic            saturated_o
);
  import bbt_pkg::*;

  coord_t coef [NUM_COEF];
  coord_t lo [NUM_AXES];
  coord_t hi [NUM_AXES];
  prod_t  plo [NUM_AXES][NUM_AXES];
  prod_t  phi [NUM_AXES][NUM_AXES];
  prod_t  tmin [NUM_AXES][NUM_AXES];
  prod_t  tmax [NUM_AXES][NUM_AXES];
  coord_t trans1 [NUM_AXES];
  coord_t trans2 [NUM_AXES];
  sum_t   smin [NUM_AXES];
  sum_t   smax [NUM_AXES];
  coord_t rmin [NUM_AXES];
  coord_t rmax [NUM_AXES];
  logic   rdy1, rdy2, rdy3, rdy4;
  logic   vld1, vld2, vld3;
  logic   accept;
  logic   load;
  logic   xform;

  assign coef = '{coef_0_i, coef_1_i, coef_2_i, coef_3_i};
  assign lo   = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi   = '{box_max_x_i, box_max_y_i, box_max_z_i};

  assign in_stall_o = !rdy1;
  assign accept     = in_valid_i && rdy1;
  assign load       = accept && (opcode_i == OP_LOAD);
  assign xform      = in_valid_i && (opcode_i == OP_XFORM);

  bbt_mul #(.FracBits(FracBits)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .row_i   (row_index_i),
    .coef_i  (coef),
    .valid_i (xform),
    .ready_o (rdy1),
    .lo_i    (lo),
    .hi_i    (hi),
    .valid_o (vld1),
    .ready_i (rdy2),
    .plo_o   (plo),
    .phi_o   (phi),
    .trans_o (trans1)
  );

  bbt_minmax u_minmax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld1),
    .ready_o (rdy2),
    .plo_i   (plo),
    .phi_i   (phi),
    .trans_i (trans1),
    .valid_o (vld2),
    .ready_i (rdy3),
    .tmin_o  (tmin),
    .tmax_o  (tmax),
    .trans_o (trans2)
  );

  bbt_sum #(.FracBits(FracBits)) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld2),
    .ready_o (rdy3),
    .tmin_i  (tmin),
    .tmax_i  (tmax),
    .trans_i (trans2),
    .valid_o (vld3),
    .ready_i (rdy4),
    .smin_o  (smin),
    .smax_o  (smax)
  );

  bbt_sat #(.FracBits(FracBits), .CoordWidth(CoordWidth)) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld3),
    .ready_o (rdy4),
    .smin_i  (smin),
    .smax_i  (smax),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .min_o   (rmin),
    .max_o   (rmax),
    .sat_o   (saturated_o)
  );

  assign new_min_x_o = rmin[0];
  assign new_min_y_o = rmin[1];
  assign new_min_z_o = rmin[2];
  assign new_max_x_o = rmax[0];
  assign new_max_y_o = rmax[1];
  assign new_max_z_o = rmax[2];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output stage");

endmodule

// ===== sv/bbt_mul.sv =====
// Matrix row storage and the corner-term product stage.
module bbt_mul #(
  parameter int FracBits = bbt_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  bbt_pkg::row_t   row_i,
  input  bbt_pkg::coord_t coef_i [4],
  input  logic            valid_i,
  output logic            ready_o,
  input  bbt_pkg::coord_t lo_i [3],
  input  bbt_pkg::coord_t hi_i [3],
  output logic            valid_o,
  input  logic            ready_i,
  output bbt_pkg::prod_t  plo_o [3][3],
  output bbt_pkg::prod_t  phi_o [3][3],
  output bbt_pkg::coord_t trans_o [3]
);
  import bbt_pkg::*;

  localparam coord_t One = coord_t'(1) << FracBits;

  coord_t m_q [NUM_AXES][NUM_COEF];
  prod_t  plo_d [NUM_AXES][NUM_AXES];
  prod_t  phi_d [NUM_AXES][NUM_AXES];
  prod_t  plo_q [NUM_AXES][NUM_AXES];
  prod_t  phi_q [NUM_AXES][NUM_AXES];
  coord_t trans_q [NUM_AXES];
  logic   valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign plo_o   = plo_q;
  assign phi_o   = phi_q;
  assign trans_o = trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_COEF; c++) begin
          m_q[r][c] <= (r == c) ? One : '0;
        end
      end
    end else if (load_i) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        if (row_i == ROW_W'(r)) begin
          for (int c = 0; c < NUM_COEF; c++) begin
            m_q[r][c] <= coef_i[c];
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        plo_d[a][j] = prod_t'(m_q[a][j]) * prod_t'(lo_i[j]);
        phi_d[a][j] = prod_t'(m_q[a][j]) * prod_t'(hi_i[j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      for (int a = 0; a < NUM_AXES; a++) begin
        trans_q[a] <= m_q[a][NUM_COEF-1];
      end
    end
  end

  for (genvar r = 0; r < NUM_AXES; r++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (load_i && row_i == ROW_W'(r)) |=>
        (m_q[r][0] == $past(coef_i[0]) && m_q[r][3] == $past(coef_i[3])))
      else $error("matrix row not written by load");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> valid_q)
    else $error("product stage dropped a held box");

endmodule

// ===== sv/bbt_minmax.sv =====
// Per-term minimum and maximum over the two box bounds.
module bbt_minmax (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bbt_pkg::prod_t  plo_i [3][3],
  input  bbt_pkg::prod_t  phi_i [3][3],
  input  bbt_pkg::coord_t trans_i [3],
  output logic            valid_o,
  input  logic            ready_i,
  output bbt_pkg::prod_t  tmin_o [3][3],
  output bbt_pkg::prod_t  tmax_o [3][3],
  output bbt_pkg::coord_t trans_o [3]
);
  import bbt_pkg::*;

  prod_t  tmin_d [NUM_AXES][NUM_AXES];
  prod_t  tmax_d [NUM_AXES][NUM_AXES];
  prod_t  tmin_q [NUM_AXES][NUM_AXES];
  prod_t  tmax_q [NUM_AXES][NUM_AXES];
  coord_t trans_q [NUM_AXES];
  logic   valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign tmin_o  = tmin_q;
  assign tmax_o  = tmax_q;
  assign trans_o = trans_q;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        if (plo_i[a][j] < phi_i[a][j]) begin
          tmin_d[a][j] = plo_i[a][j];
          tmax_d[a][j] = phi_i[a][j];
        end else begin
          tmin_d[a][j] = phi_i[a][j];
          tmax_d[a][j] = plo_i[a][j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      tmin_q  <= tmin_d;
      tmax_q  <= tmax_d;
      trans_q <= trans_i;
    end
  end

endmodule

// ===== sv/bbt_sum.sv =====
// Exact sum of the term extremes and the aligned translation per axis.
module bbt_sum #(
  parameter int FracBits = bbt_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bbt_pkg::prod_t  tmin_i [3][3],
  input  bbt_pkg::prod_t  tmax_i [3][3],
  input  bbt_pkg::coord_t trans_i [3],
  output logic            valid_o,
  input  logic            ready_i,
  output bbt_pkg::sum_t   smin_o [3],
  output bbt_pkg::sum_t   smax_o [3]
);
  import bbt_pkg::*;

  sum_t smin_d [NUM_AXES];
  sum_t smax_d [NUM_AXES];
  sum_t smin_q [NUM_AXES];
  sum_t smax_q [NUM_AXES];
  sum_t tr;
  logic valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign smin_o  = smin_q;
  assign smax_o  = smax_q;

  always_comb begin
    tr = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      tr        = sum_t'(trans_i[a]) <<< FracBits;
      smin_d[a] = sum_t'(tmin_i[a][0]) + sum_t'(tmin_i[a][1])
                + sum_t'(tmin_i[a][2]) + tr;
      smax_d[a] = sum_t'(tmax_i[a][0]) + sum_t'(tmax_i[a][1])
                + sum_t'(tmax_i[a][2]) + tr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      smin_q <= smin_d;
      smax_q <= smax_d;
    end
  end

endmodule

// ===== sv/bbt_sat.sv =====
// Truncation, saturation and the output register.
module bbt_sat #(
  parameter int FracBits   = bbt_pkg::FRAC_BITS_DEF,
  parameter int CoordWidth = bbt_pkg::COORD_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bbt_pkg::sum_t   smin_i [3],
  input  bbt_pkg::sum_t   smax_i [3],
  output logic            valid_o,
  input  logic            stall_i,
  output bbt_pkg::coord_t min_o [3],
  output bbt_pkg::coord_t max_o [3],
  output logic            sat_o
);
  import bbt_pkg::*;

  localparam int   SatW   = (CoordWidth < DATA_W) ? CoordWidth : DATA_W;
  localparam sum_t SatMax = (sum_t'(1) <<< (SatW - 1)) - sum_t'(1);
  localparam sum_t SatMin = -SatMax - sum_t'(1);

  coord_t min_d [NUM_AXES];
  coord_t max_d [NUM_AXES];
  coord_t min_q [NUM_AXES];
  coord_t max_q [NUM_AXES];
  sum_t   vmin;
  sum_t   vmax;
  logic   sat_d;
  logic   sat_q;
  logic   valid_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign min_o   = min_q;
  assign max_o   = max_q;
  assign sat_o   = sat_q;

  always_comb begin
    sat_d = 1'b0;
    vmin  = '0;
    vmax  = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      vmin = smin_i[a] >>> FracBits;
      vmax = smax_i[a] >>> FracBits;
      if (vmin < SatMin) begin
        vmin  = SatMin;
        sat_d = 1'b1;
      end else if (vmin > SatMax) begin
        vmin  = SatMax;
        sat_d = 1'b1;
      end
      if (vmax > SatMax) begin
        vmax  = SatMax;
        sat_d = 1'b1;
      end else if (vmax < SatMin) begin
        vmax  = SatMin;
        sat_d = 1'b1;
      end
      min_d[a] = vmin[DATA_W-1:0];
      max_d[a] = vmax[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      min_q <= min_d;
      max_q <= max_d;
      sat_q <= sat_d;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_q |-> (min_q[a] <= max_q[a]))
      else $error("result minimum exceeds maximum");
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for box_bounds_transform against a fixed-point predictor.
module tb_top;
  import bbt_pkg::*;

  localparam int FRAC_BITS      = FRAC_BITS_DEF;
  localparam int SAT_W          = COORD_WIDTH_DEF < 32 ? COORD_WIDTH_DEF : 32;
  localparam int RANDOM_ITEMS   = 450;
  localparam int FLOOD_ITEMS    = 40;
  localparam int HOLD_OFF       = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [79:0] SAT_MAX = (80'sd1 <<< (SAT_W - 1)) - 80'sd1;
  localparam logic signed [79:0] SAT_MIN = -SAT_MAX - 80'sd1;

  localparam row_t ROW_X    = 2'd0;
  localparam row_t ROW_Y    = 2'd1;
  localparam row_t ROW_Z    = 2'd2;
  localparam row_t ROW_NONE = 2'd3;

  localparam coord_t Q_ONE = 32'sh0001_0000;
  localparam coord_t Q_MAX = 32'sh7fff_ffff;
  localparam coord_t Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    logic   sat;
  } bounds_t;

  logic   clk = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   opcode = OP_LOAD;
  row_t   row_index = '0;
  coord_t coef_0 = '0;
  coord_t coef_1 = '0;
  coord_t coef_2 = '0;
  coord_t coef_3 = '0;
  coord_t box_min_x = '0;
  coord_t box_min_y = '0;
  coord_t box_min_z = '0;
  coord_t box_max_x = '0;
  coord_t box_max_y = '0;
  coord_t box_max_z = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t new_min_x;
  coord_t new_min_y;
  coord_t new_min_z;
  coord_t new_max_x;
  coord_t new_max_y;
  coord_t new_max_z;
  logic   saturated;

  coord_t  row_coef [3][4];
  bounds_t expected_boxes [$];

  bit idling = 1'b1;
  bit out_fire = 1'b0;
  int hold_cycles = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int boxes_sent = 0;
  int boxes_checked = 0;
  int saturated_seen = 0;
  int rows_loaded = 0;
  int rows_ignored = 0;

  box_bounds_transform uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (opcode),
    .row_index_i (row_index),
    .coef_0_i    (coef_0),
    .coef_1_i    (coef_1),
    .coef_2_i    (coef_2),
    .coef_3_i    (coef_3),
    .box_min_x_i (box_min_x),
    .box_min_y_i (box_min_y),
    .box_min_z_i (box_min_z),
    .box_max_x_i (box_max_x),
    .box_max_y_i (box_max_y),
    .box_max_z_i (box_max_z),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .new_min_x_o (new_min_x),
    .new_min_y_o (new_min_y),
    .new_min_z_o (new_min_z),
    .new_max_x_o (new_max_x),
    .new_max_y_o (new_max_y),
    .new_max_z_o (new_max_z),
    .saturated_o (saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic load_identity();
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        row_coef[r][k] = (r == k) ? Q_ONE : '0;
      end
    end
  endtask

  function automatic bounds_t transform_box(coord_t lx, coord_t ly, coord_t lz,
                                            coord_t hx, coord_t hy, coord_t hz);
    bounds_t r;
    coord_t lo [3];
    coord_t hi [3];
    coord_t pt [3];
    coord_t mn [3];
    coord_t mx [3];
    coord_t v;
    logic signed [79:0] acc;
    logic sat;
    lo[0] = lx; lo[1] = ly; lo[2] = lz;
    hi[0] = hx; hi[1] = hy; hi[2] = hz;
    sat = 1'b0;
    for (int c = 0; c < 8; c++) begin
      pt[0] = c[2] ? hi[0] : lo[0];
      pt[1] = c[1] ? hi[1] : lo[1];
      pt[2] = c[0] ? hi[2] : lo[2];
      for (int a = 0; a < 3; a++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          acc = acc + 80'(longint'(row_coef[a][k]) * longint'(pt[k]));
        end
        acc = acc + (80'(longint'(row_coef[a][3])) <<< FRAC_BITS);
        acc = acc >>> FRAC_BITS;
        if (acc > SAT_MAX) begin
          sat = 1'b1;
          acc = SAT_MAX;
        end else if (acc < SAT_MIN) begin
          sat = 1'b1;
          acc = SAT_MIN;
        end
        v = coord_t'(acc);
        if (c == 0 || v < mn[a]) mn[a] = v;
        if (c == 0 || v > mx[a]) mx[a] = v;
      end
    end
    r.min_x = mn[0]; r.min_y = mn[1]; r.min_z = mn[2];
    r.max_x = mx[0]; r.max_y = mx[1]; r.max_z = mx[2];
    r.sat = sat;
    return r;
  endfunction

  function automatic coord_t rand_span(int unsigned span);
    return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
  endfunction

  function automatic coord_t rand_extreme();
    case ($urandom_range(0, 4))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return Q_ONE;
    endcase
  endfunction

  function automatic coord_t rand_coef();
    case ($urandom_range(0, 9))
      0, 1: return coord_t'($urandom);
      2: return rand_extreme();
      default: return rand_span(1 << 18);
    endcase
  endfunction

  function automatic coord_t rand_bound();
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom);
      1: return rand_extreme();
      default: return rand_span(1 << 24);
    endcase
  endfunction

  task automatic send_beat(logic op, row_t row, coord_t c0, coord_t c1, coord_t c2,
                           coord_t c3, coord_t lx, coord_t ly, coord_t lz,
                           coord_t hx, coord_t hy, coord_t hz);
    int gap;
    bit taken;
    bounds_t want;
    gap = idling ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    row_index <= row;
    coef_0    <= c0;
    coef_1    <= c1;
    coef_2    <= c2;
    coef_3    <= c3;
    box_min_x <= lx;
    box_min_y <= ly;
    box_min_z <= lz;
    box_max_x <= hx;
    box_max_y <= hy;
    box_max_z <= hz;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (op == OP_LOAD) begin
      if (row == ROW_NONE) begin
        rows_ignored++;
      end else begin
        row_coef[row][0] = c0;
        row_coef[row][1] = c1;
        row_coef[row][2] = c2;
        row_coef[row][3] = c3;
        rows_loaded++;
      end
    end else begin
      want = transform_box(lx, ly, lz, hx, hy, hz);
      if (want.sat) saturated_seen++;
      expected_boxes.push_back(want);
      boxes_sent++;
    end
  endtask

  task automatic load_row(row_t row, coord_t c0, coord_t c1, coord_t c2, coord_t c3);
    send_beat(OP_LOAD, row, c0, c1, c2, c3, rand_bound(), rand_bound(), rand_bound(),
              rand_bound(), rand_bound(), rand_bound());
  endtask

  task automatic send_box(coord_t lx, coord_t ly, coord_t lz,
                          coord_t hx, coord_t hy, coord_t hz);
    send_beat(OP_XFORM, row_t'($urandom_range(0, 3)), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              lx, ly, lz, hx, hy, hz);
  endtask

  task automatic send_random_box();
    coord_t lo [3];
    coord_t hi [3];
    coord_t t;
    for (int a = 0; a < 3; a++) begin
      lo[a] = rand_bound();
      hi[a] = rand_bound();
      if ($urandom_range(0, 9) < 7 && lo[a] > hi[a]) begin
        t = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
    end
    send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_identity_boxes();
    send_box(-32'sd65536, 32'sd131072, 32'sd7, 32'sd196608, 32'sd262144, 32'sd9000);
    send_box(32'sd500000, 32'sd100, -32'sd3, -32'sd500000, -32'sd100, 32'sd3);
    send_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
  endtask

  task automatic test_row_loads();
    load_row(ROW_X, 32'sd131072, '0, '0, 32'sd327680);
    load_row(ROW_Y, '0, -32'sd65536, 32'sd32768, -32'sd1000);
    load_row(ROW_Z, 32'sd46341, 32'sd46341, '0, '0);
    load_row(ROW_NONE, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_box(-32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536);
  endtask

  task automatic test_saturation();
    load_row(ROW_X, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    load_row(ROW_Y, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    load_row(ROW_Z, Q_MAX, Q_MIN, -32'sd1, '0);
    send_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    send_box(-32'sd1, '0, 32'sd1, 32'sd1, '0, -32'sd1);
    load_row(ROW_X, Q_ONE, '0, '0, '0);
    load_row(ROW_Y, '0, Q_ONE, '0, '0);
    load_row(ROW_Z, '0, '0, Q_ONE, '0);
    send_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) idling = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 12) begin
        load_row(row_t'($urandom_range(0, 3)), rand_coef(), rand_coef(), rand_coef(),
                 rand_bound());
      end else begin
        send_random_box();
      end
      if (i % 150 == 149) wait_drained();
    end
    idling = 1'b1;
  endtask

  task automatic test_backpressure();
    idling = 1'b0;
    hold_cycles = HOLD_OFF;
    repeat (FLOOD_ITEMS) send_random_box();
    idling = 1'b1;
  endtask

  // hold off for a drawn number of cycles after each result beat while idling, or for the hold_cycles a test sets
  always @(posedge clk) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        stall_left = hold_cycles;
        hold_cycles = 0;
      end else if (out_fire) begin
        stall_left = idling ? $urandom_range(0, 19) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic note_field(string name, coord_t want, coord_t got);
    if (want !== got) begin
      if (errors < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h got %h", $realtime, name, want, got);
      end
      errors++;
    end
  endtask

  always @(negedge clk) begin
    bounds_t want;
    bit in_fire;
    out_fire = rst_ni && out_valid && !out_stall;
    in_fire = rst_ni && in_valid && !in_stall;
    if (out_fire) begin
      if (expected_boxes.size() == 0) begin
        if (errors < MAX_REPORTS) $display("%0t: result beat with none expected", $realtime);
        errors++;
      end else begin
        want = expected_boxes.pop_front();
        note_field("new_min_x", want.min_x, new_min_x);
        note_field("new_min_y", want.min_y, new_min_y);
        note_field("new_min_z", want.min_z, new_min_z);
        note_field("new_max_x", want.max_x, new_max_x);
        note_field("new_max_y", want.max_y, new_max_y);
        note_field("new_max_z", want.max_z, new_max_z);
        note_field("saturated", coord_t'(want.sat), coord_t'(saturated));
        boxes_checked++;
      end
    end
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    load_identity();
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_identity_boxes();
    wait_drained();
    test_row_loads();
    wait_drained();
    test_saturation();
    wait_drained();
    test_random_stream();
    wait_drained();
    test_backpressure();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d of %0d boxes (%0d saturating), %0d row loads, %0d to row three.",
             boxes_checked, boxes_sent, saturated_seen, rows_loaded, rows_ignored);
    $display("Random gaps, a %0d-cycle output hold-off and drain pauses; %0d mismatches.",
             HOLD_OFF, errors);
    if (errors == 0 && expected_boxes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bbt_pkg.sv
sv/bbt_mul.sv
sv/bbt_minmax.sv
sv/bbt_sum.sv
sv/bbt_sat.sv
sv/box_bounds_transform.sv
test/tb_top.sv
